// ----- hdl/lwc_pkg.sv -----
// Shared types for the LRU write-back cache core.
`timescale 1ns / 1ps

package lwc_pkg;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_t;

endpackage

// ----- hdl/lru_writeback_cache_core.sv -----
// Fully associative key/value cache with LRU replacement and dirty write-back.
`timescale 1ns / 1ps

// Command channel: a word (kind, key, value_in) is taken at a rising edge with start high
// and busy low. Keys keep their low KEY_BITS bits and values their low VALUE_BITS bits.
// Result channel: done is high for exactly one cycle with hit, read_value and the
// write-back fields valid; the receiver cannot hold it off, so nothing waits on it.
// Every command produces exactly one result.
// The time a command takes grows with the number of valid entries; one command is in
// flight at a time, and a new one may be accepted in the cycle that done is shown.
// The time is set by walks over the single read port of the entry memories: every
// command has one that compares every key and finds the least recent entry, and all
// but a lookup miss have a second that rewrites every recency rank after the slot to
// promote is known.
// Reset (rst, synchronous) empties the cache and clears the dirty marks; the key,
// value and rank memories need no clearing since only filled slots are ever read.

module lru_writeback_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lwc_pkg::kind_t kind,
  input  logic [63:0]    key,
  input  logic [63:0]    value_in,
  output logic           done,
  output logic           hit,
  output logic [63:0]    read_value,
  output logic           writeback_valid,
  output logic [63:0]    writeback_key,
  output logic [63:0]    writeback_value
);

  import lwc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_RANK = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_UPDATE
  } state_t;

  state_t state;

  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
  logic [IW-1:0]         rank_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [IW-1:0]         rank_q;

  logic [ENTRIES-1:0]    dirty;
  logic [CW-1:0]         count;
  logic [CW-1:0]         issue_idx;
  logic                  chk_vld;
  logic [IW-1:0]         chk_idx;

  kind_t                 req_kind;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  logic                  found;
  logic [IW-1:0]         found_slot;
  logic [IW-1:0]         found_rank;
  logic [VALUE_BITS-1:0] found_value;
  logic [IW-1:0]         vic_slot;
  logic [KEY_BITS-1:0]   vic_key;
  logic [VALUE_BITS-1:0] vic_value;

  logic [IW-1:0]         slot;
  logic [IW-1:0]         old_rank;

  logic                  full;
  logic                  is_insert;
  logic [IW-1:0]         dec_slot;
  logic [IW-1:0]         dec_old;
  logic [IW-1:0]         rank_next;
  logic                  issue_more;

  assign full       = (count == CW'(ENTRIES));
  assign is_insert  = (req_kind == KIND_INSERT);
  assign issue_more = (issue_idx < count);

  always_comb begin
    if (found) begin
      dec_slot = found_slot;
      dec_old  = found_rank;
    end else if (full) begin
      dec_slot = vic_slot;
      dec_old  = LAST_RANK;
    end else begin
      dec_slot = count[IW-1:0];
      dec_old  = count[IW-1:0];
    end
  end

  always_comb begin
    if (chk_idx == slot) begin
      rank_next = '0;
    end else if (rank_q < old_rank) begin
      rank_next = rank_q + IW'(1);
    end else begin
      rank_next = rank_q;
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[issue_idx[IW-1:0]];
    val_q  <= val_mem[issue_idx[IW-1:0]];
    rank_q <= rank_mem[issue_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && is_insert) begin
      val_mem[dec_slot] <= req_val;
      if (!found) begin
        key_mem[dec_slot] <= req_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE && chk_vld) begin
      rank_mem[chk_idx] <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      done      <= 1'b0;
      count     <= '0;
      dirty     <= '0;
      issue_idx <= '0;
      chk_vld   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_kind  <= kind;
            req_key   <= key[KEY_BITS-1:0];
            req_val   <= value_in[VALUE_BITS-1:0];
            found     <= 1'b0;
            issue_idx <= '0;
            chk_vld   <= 1'b0;
            busy      <= 1'b1;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (chk_vld) begin
            if (key_q == req_key && !found) begin
              found       <= 1'b1;
              found_slot  <= chk_idx;
              found_rank  <= rank_q;
              found_value <= val_q;
            end
            if (rank_q == LAST_RANK) begin
              vic_slot  <= chk_idx;
              vic_key   <= key_q;
              vic_value <= val_q;
            end
          end
          if (issue_more) begin
            chk_vld   <= 1'b1;
            chk_idx   <= issue_idx[IW-1:0];
            issue_idx <= issue_idx + CW'(1);
          end else begin
            chk_vld <= 1'b0;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          hit             <= found;
          read_value      <= (found && !is_insert) ? 64'(found_value) : '0;
          writeback_valid <= 1'b0;
          writeback_key   <= '0;
          writeback_value <= '0;
          slot            <= dec_slot;
          old_rank        <= dec_old;
          issue_idx       <= '0;
          chk_vld         <= 1'b0;
          if (is_insert) begin
            dirty[dec_slot] <= 1'b1;
            if (!found) begin
              if (full) begin
                if (dirty[vic_slot]) begin
                  writeback_valid <= 1'b1;
                  writeback_key   <= 64'(vic_key);
                  writeback_value <= 64'(vic_value);
                end
              end else begin
                count <= count + CW'(1);
              end
            end
          end
          if (found || is_insert) begin
            state <= S_UPDATE;
          end else begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_UPDATE: begin
          if (issue_more) begin
            chk_vld   <= 1'b1;
            chk_idx   <= issue_idx[IW-1:0];
            issue_idx <= issue_idx + CW'(1);
          end else begin
            chk_vld <= 1'b0;
            done    <= 1'b1;
            busy    <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/lwc_checker.sv -----
// Port-level checks for the LRU write-back cache core, bound to the top level.
`timescale 1ns / 1ps

module lwc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input lwc_pkg::kind_t kind,
  input logic           done,
  input logic           hit,
  input logic [63:0]    read_value,
  input logic           writeback_valid
);

  import lwc_pkg::*;

  kind_t last_kind;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_kind <= kind;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted word did not raise busy.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("Result strobe without a command in flight.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> read_value == 64'd0)
    else $error("Miss returned a nonzero read value.");

  a_wb_insert_miss: assert property (@(posedge clk) disable iff (rst)
    done && writeback_valid |-> !hit && last_kind == KIND_INSERT)
    else $error("Write-back reported outside an insert miss.");

endmodule

bind lru_writeback_cache_core lwc_checker u_lwc_checker (.*);

// ----- tb/tb_lru_writeback_cache_core.sv -----
// Self-checking testbench for the LRU write-back cache core with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
  logic        hit;
  logic [63:0] read_value;
  logic        wb_valid;
  logic [63:0] wb_key;
  logic [63:0] wb_value;
} cache_result_t;

class lru_cache_tracker;
  localparam int SLOTS = 16;

  cache_result_t pending_results[$];
  logic [63:0]   key_mem[SLOTS];
  logic [63:0]   val_mem[SLOTS];
  bit            dirty[SLOTS];
  int            rank[SLOTS];
  int            fill;
  int            errors;
  int            lookups;
  int            inserts;
  int            hits_seen;
  int            writebacks_seen;

  function new();
    fill = 0;
    errors = 0;
    lookups = 0;
    inserts = 0;
    hits_seen = 0;
    writebacks_seen = 0;
    for (int i = 0; i < SLOTS; i++) begin
      dirty[i] = 1'b0;
      rank[i] = 0;
    end
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  function void promote(int slot);
    int old;
    old = rank[slot];
    for (int j = 0; j < fill; j++) begin
      if (j != slot && rank[j] < old) rank[j]++;
    end
    rank[slot] = 0;
  endfunction

  function void note_command(lwc_pkg::kind_t k, logic [63:0] ky, logic [63:0] v);
    cache_result_t r;
    int            slot;
    bit            found;
    int            worst;
    r = '0;
    slot = 0;
    found = 1'b0;
    if (k == lwc_pkg::KIND_LOOKUP) lookups++;
    else inserts++;
    for (int i = 0; i < fill; i++) begin
      if (!found && key_mem[i] == ky) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      promote(slot);
      r.hit = 1'b1;
      if (k == lwc_pkg::KIND_LOOKUP) begin
        r.read_value = val_mem[slot];
      end else begin
        val_mem[slot] = v;
        dirty[slot] = 1'b1;
      end
    end else if (k == lwc_pkg::KIND_INSERT) begin
      if (fill < SLOTS) begin
        slot = fill;
        fill++;
        rank[slot] = fill - 1;
      end else begin
        worst = 0;
        slot = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (rank[i] >= worst) begin
            worst = rank[i];
            slot = i;
          end
        end
        if (dirty[slot]) begin
          r.wb_valid = 1'b1;
          r.wb_key = key_mem[slot];
          r.wb_value = val_mem[slot];
        end
      end
      key_mem[slot] = ky;
      val_mem[slot] = v;
      dirty[slot] = 1'b1;
      promote(slot);
    end
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task check_result(cache_result_t got);
    cache_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending, hit", 64'(got.hit), 64'd0);
    end else begin
      want = pending_results.pop_front();
      if (want.hit) hits_seen++;
      if (want.wb_valid) writebacks_seen++;
      if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.wb_valid !== want.wb_valid)
        report_mismatch("writeback_valid", 64'(got.wb_valid), 64'(want.wb_valid));
      if (got.wb_key !== want.wb_key)
        report_mismatch("writeback_key", got.wb_key, want.wb_key);
      if (got.wb_value !== want.wb_value)
        report_mismatch("writeback_value", got.wb_value, want.wb_value);
    end
  endtask
endclass

module tb_lru_writeback_cache_core;
  import lwc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int POOL_SIZE  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  kind_t       kind = KIND_LOOKUP;
  logic [63:0] key = '0;
  logic [63:0] value_in = '0;
  logic        done;
  logic        hit;
  logic [63:0] read_value;
  logic        writeback_valid;
  logic [63:0] writeback_key;
  logic [63:0] writeback_value;

  lru_cache_tracker tracker = new();
  int               idle_cycles = 0;
  bit               no_idle = 1'b0;
  logic [63:0]      key_pool[POOL_SIZE];

  lru_writeback_cache_core #(
    .ENTRIES(16),
    .KEY_BITS(64),
    .VALUE_BITS(64)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .key(key),
    .value_in(value_in),
    .done(done),
    .hit(hit),
    .read_value(read_value),
    .writeback_valid(writeback_valid),
    .writeback_key(writeback_key),
    .writeback_value(writeback_value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result({hit, read_value, writeback_valid, writeback_key, writeback_value});
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lru_writeback_cache_core: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input kind_t k, input logic [63:0] ky, input logic [63:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    key <= ky;
    value_in <= v;
    do @(posedge clk); while (busy);
    tracker.note_command(k, ky, v);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_word(input int span);
    int          pick;
    logic [63:0] ky;
    pick = $urandom_range(0, 99);
    if (pick < 88) ky = key_pool[$urandom_range(0, span - 1)];
    else if (pick < 95) ky = rand64();
    else ky = $urandom_range(0, 1) ? '1 : '0;
    send_word(kind_t'($urandom_range(0, 1)), ky, rand64());
  endtask

  initial begin
    int spans[4];
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();
    spans = '{10, 20, 40, 24};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A lookup on the empty cache, hits and an update, then a fill past capacity.
    send_word(KIND_LOOKUP, rand64(), rand64());
    send_word(KIND_INSERT, '0, '1);
    send_word(KIND_INSERT, '1, '0);
    send_word(KIND_LOOKUP, '0, rand64());
    send_word(KIND_LOOKUP, '1, rand64());
    send_word(KIND_INSERT, '0, rand64());
    send_word(KIND_LOOKUP, '0, '1);
    for (int i = 0; i < 14; i++) send_word(KIND_INSERT, rand64(), rand64());
    send_word(KIND_INSERT, rand64(), rand64());
    send_word(KIND_LOOKUP, '1, rand64());
    send_word(KIND_LOOKUP, '0, rand64());

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      no_idle = (phase == 2);
      for (int n = 0; n < 240; n++) begin
        if (phase != 2 && $urandom_range(0, 39) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 99) == 0) drain_results();
        random_word(spans[phase]);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Ran %0d lookups and %0d inserts through the cache.",
             tracker.lookups, tracker.inserts);
    $display("Checked %0d hits and %0d dirty evictions.",
             tracker.hits_seen, tracker.writebacks_seen);
    if (tracker.errors == 0) begin
      $display("tb_lru_writeback_cache_core: done, clean");
    end else begin
      $display("tb_lru_writeback_cache_core: done, errors");
    end
    $finish;
  end
endmodule
